// ===== rtl/core/cms_pkg.sv =====
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types and constants for the count-min sketch.
// ----------------------------------------------------------------------------
`default_nettype none

package cms_pkg;

    localparam int DEPTH_DEF      = 4;
    localparam int WIDTH_BITS_DEF = 10;

    // Hash takes the column from bit 31 of the row product upwards
    localparam int HASH_SHIFT = 31;
    localparam int COEF_W     = 31;
    localparam int MAX_ROWS   = 4;
    localparam int ROW_SEL_W  = 2;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0_MULT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_ADD  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_MULT = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_ADD  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_MULT = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_ADD  = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_MULT = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_ADD  = CFG_IDX_W'(7);

    localparam logic CMD_ADD      = 1'b0;
    localparam logic CMD_ESTIMATE = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] key;
        logic signed [31:0] increment;
    } in_item_t;

    typedef struct packed {
        logic [31:0] estimate;
        logic [31:0] total;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/cms_hash.sv =====
// ----------------------------------------------------------------------------
// cms_hash
// Shared row hash: registered multiply, then add and column select.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_hash #(
    parameter int WIDTH_BITS = cms_pkg::WIDTH_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic [cms_pkg::COEF_W-1:0]    mult_i,
    input  wire logic [cms_pkg::COEF_W-1:0]    add_i,
    input  wire logic signed [31:0]            key_i,
    output logic      [WIDTH_BITS-1:0]         col_o
);
    import cms_pkg::*;

    // Only the bits up to the top of the column matter; the rest wrap away
    localparam int PROD_W = HASH_SHIFT + WIDTH_BITS;

    logic signed [31:0]     mult_s;
    logic signed [63:0]     prod_full;
    logic [PROD_W-1:0]      prod_reg;
    logic [PROD_W-1:0]      sum;
    logic [WIDTH_BITS-1:0]  col_reg;

    // Both operands are 32-bit signed; the product is the full 64 bits
    assign mult_s    = $signed({1'b0, mult_i});
    assign prod_full = 64'(mult_s) * 64'(key_i);
    assign sum       = prod_reg + PROD_W'(add_i);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_full[PROD_W-1:0];
        col_reg  <= sum[HASH_SHIFT +: WIDTH_BITS];
    end

    assign col_o = col_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cms_mem.sv =====
// ----------------------------------------------------------------------------
// cms_mem
// Counter store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_mem #(
    parameter int MEM_DEPTH = cms_pkg::DEPTH_DEF << cms_pkg::WIDTH_BITS_DEF,
    parameter int ADDR_W    = $clog2(MEM_DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we_i,
    input  wire logic [ADDR_W-1:0] waddr_i,
    input  wire logic [31:0]       wdata_i,
    input  wire logic [ADDR_W-1:0] raddr_i,
    output logic      [31:0]       rdata_o
);
    logic [31:0] mem [0:MEM_DEPTH-1];
    logic [31:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we_i) begin
            mem[waddr_i] <= wdata_i;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr_i];
    end

    assign rdata_o = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/count_min_sketch.sv =====
// ----------------------------------------------------------------------------
// count_min_sketch
// Count-min sketch over pre-hashed keys, one shared hash unit and one store.
// ----------------------------------------------------------------------------
// Input channel s_*: one transaction per item, cmd selects add or estimate.
// Result channel m_*: one transaction per estimate (minimum counter, total);
// an add gives none. Configuration channel cfg_*: eight hash coefficients,
// always ready; indexes past the list are ignored.
// Each item visits the rows in turn, with the steps multiply, add and column
// select, read and update for each row, all through the one multiplier and the
// one read port of the counter store. An add frees the block after the update
// of its last row, an estimate once its result is loaded into the output
// register, which also puts it on m_valid; s_ready is then high again.
// After reset all DEPTH*2^WIDTH_BITS words of the counter store (4096 by
// default) are swept to zero, one word a cycle, with s_ready low.
// A finished result waits in the output register while m_ready is low; a
// new item is still taken, and a later estimate holds at its final step
// until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module count_min_sketch #(
    parameter int DEPTH      = cms_pkg::DEPTH_DEF,
    parameter int WIDTH_BITS = cms_pkg::WIDTH_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire cms_pkg::in_item_t              s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output cms_pkg::out_item_t                  m_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [cms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cms_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cms_pkg::*;

    localparam int MEM_DEPTH = DEPTH << WIDTH_BITS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int ROW_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_HASH = 3'd3;
    localparam logic [2:0] ST_RD   = 3'd4;
    localparam logic [2:0] ST_UPD  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [ADDR_W-1:0]      clr_addr_reg, clr_addr_next;
    logic                   cmd_reg;
    logic signed [31:0]     key_reg;
    logic [31:0]            inc_reg;
    logic [31:0]            min_reg, min_next;
    logic [31:0]            total_reg, total_next;
    out_item_t              out_reg;
    logic                   m_valid_reg, m_valid_next;
    logic                   out_load;

    logic [COEF_W-1:0]      mult_reg [0:MAX_ROWS-1];
    logic [COEF_W-1:0]      add_reg  [0:MAX_ROWS-1];
    logic [ROW_SEL_W-1:0]   row_sel;

    logic [WIDTH_BITS-1:0]  col;
    logic [ADDR_W-1:0]      rc_addr;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [31:0]            mem_wdata;
    logic [31:0]            mem_rdata;
    logic                   s_fire;
    logic                   last_row;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign row_sel   = ROW_SEL_W'(row_reg);
    assign last_row  = (row_reg == ROW_W'(DEPTH - 1));
    assign rc_addr   = ADDR_W'({row_reg, col});

    // Coefficient registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_ROWS; i++) begin
                mult_reg[i] <= COEF_W'(1);
                add_reg[i]  <= COEF_W'(1);
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ROW0_MULT: mult_reg[0] <= cfg_data[COEF_W-1:0];
                REG_ROW0_ADD:  add_reg[0]  <= cfg_data[COEF_W-1:0];
                REG_ROW1_MULT: mult_reg[1] <= cfg_data[COEF_W-1:0];
                REG_ROW1_ADD:  add_reg[1]  <= cfg_data[COEF_W-1:0];
                REG_ROW2_MULT: mult_reg[2] <= cfg_data[COEF_W-1:0];
                REG_ROW2_ADD:  add_reg[2]  <= cfg_data[COEF_W-1:0];
                REG_ROW3_MULT: mult_reg[3] <= cfg_data[COEF_W-1:0];
                REG_ROW3_ADD:  add_reg[3]  <= cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    cms_hash #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_hash (
        .aclk   (aclk),
        .mult_i (mult_reg[row_sel]),
        .add_i  (add_reg[row_sel]),
        .key_i  (key_reg),
        .col_o  (col)
    );

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = rc_addr;
        mem_wdata = mem_rdata + inc_reg;
        if (state_reg == ST_CLR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else if (state_reg == ST_UPD && cmd_reg == CMD_ADD) begin
            mem_we    = 1'b1;
        end
    end

    cms_mem #(
        .MEM_DEPTH (MEM_DEPTH),
        .ADDR_W    (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .we_i    (mem_we),
        .waddr_i (mem_waddr),
        .wdata_i (mem_wdata),
        .raddr_i (rc_addr),
        .rdata_o (mem_rdata)
    );

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        row_next      = row_reg;
        clr_addr_next = clr_addr_reg;
        min_next      = min_reg;
        total_next    = total_reg;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_CLR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_MUL;
                    row_next   = '0;
                    min_next   = '1;
                    if (s_data.cmd == CMD_ADD) begin
                        total_next = total_reg + 32'(s_data.increment);
                    end
                end
            end
            ST_MUL:  state_next = ST_HASH;
            ST_HASH: state_next = ST_RD;
            ST_RD:   state_next = ST_UPD;
            ST_UPD: begin
                if (cmd_reg == CMD_ESTIMATE && mem_rdata < min_reg) begin
                    min_next = mem_rdata;
                end
                if (last_row) begin
                    state_next = (cmd_reg == CMD_ESTIMATE) ? ST_OUT : ST_IDLE;
                end else begin
                    row_next   = row_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            row_reg      <= '0;
            clr_addr_reg <= '0;
            total_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            clr_addr_reg <= clr_addr_next;
            total_reg    <= total_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        min_reg <= min_next;
        if (s_fire) begin
            cmd_reg <= s_data.cmd;
            key_reg <= s_data.key;
            inc_reg <= 32'(s_data.increment);
        end
        if (out_load) begin
            out_reg.estimate <= min_next;
            out_reg.total    <= total_reg;
        end
    end

    // Checks
    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= ROW_W'(DEPTH - 1))
        else $error("row counter beyond last row");

    a_no_take_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLR) |-> !s_fire)
        else $error("input taken during counter sweep");

    a_min_falls: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD && cmd_reg == CMD_ESTIMATE) |=> (min_reg <= $past(min_reg)))
        else $error("running minimum increased");

    a_add_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.cmd == CMD_ADD) |=> !$rose(m_valid_reg))
        else $error("add transaction raised a result");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for count_min_sketch: add and estimate transactions
// checked against a bit-accurate sketch model over several hash settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    import cms_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int ROWS            = DEPTH_DEF;
    localparam int COL_BITS        = WIDTH_BITS_DEF;
    localparam int NUM_COEF_REGS   = 8;
    localparam int SETTLE_CYCLES   = 4 * ROWS + 8;
    localparam int CYCLE_LIMIT     = 400_000;
    localparam int MAX_REPORTS     = 100;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 255;
    localparam int KEY_POOL        = 8;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    in_item_t          s_data;
    logic              m_valid;
    logic              m_ready;
    out_item_t         m_data;
    logic              cfg_valid;
    logic              cfg_ready;
    cfg_idx_t          cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Sketch model state
    logic [COEF_W-1:0] hash_coef [NUM_COEF_REGS];
    logic [31:0]       row_counters [ROWS][1 << COL_BITS];
    logic [31:0]       running_total;
    out_item_t         pending_estimates [$];

    int cycle_count   = 0;
    int error_count   = 0;
    int add_count     = 0;
    int est_count     = 0;
    int checked_count = 0;
    int coef_writes   = 0;
    int src_idle_pct  = 24;
    int snk_idle_pct  = 24;

    count_min_sketch #(
        .DEPTH      (ROWS),
        .WIDTH_BITS (COL_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    always @(negedge aclk) m_ready <= ($urandom_range(99) >= snk_idle_pct);

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR t=%0t: %s", $time, msg);
    endtask

    function automatic logic [COL_BITS-1:0] sketch_column(input int row,
                                                          input logic [31:0] key);
        logic [63:0] key_ext;
        logic [63:0] mult;
        logic [63:0] addend;
        logic [63:0] h;
        key_ext = {{32{key[31]}}, key};
        mult    = {33'd0, hash_coef[2 * row]};
        addend  = {33'd0, hash_coef[2 * row + 1]};
        h       = mult * key_ext + addend;
        return h[HASH_SHIFT +: COL_BITS];
    endfunction

    // Update the model for one accepted transaction; estimates queue a result
    function automatic void sketch_apply(input in_item_t item);
        logic [31:0]         lowest;
        logic [COL_BITS-1:0] col;
        out_item_t           res;
        if (item.cmd == CMD_ADD) begin
            running_total += item.increment;
            for (int r = 0; r < ROWS; r++) begin
                col = sketch_column(r, item.key);
                row_counters[r][col] += item.increment;
            end
            add_count++;
        end else begin
            lowest = '1;
            for (int r = 0; r < ROWS; r++) begin
                col = sketch_column(r, item.key);
                if (row_counters[r][col] < lowest)
                    lowest = row_counters[r][col];
            end
            res.estimate = lowest;
            res.total    = running_total;
            pending_estimates.push_back(res);
            est_count++;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with s_valid still high, so back-to-back transactions toggle it only for a random idle gap.
    task automatic send_op(input logic cmd, input logic [31:0] key,
                           input logic [31:0] inc);
        in_item_t item;
        item.cmd       = cmd;
        item.key       = key;
        item.increment = inc;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sketch_apply(item);
        @(negedge aclk);
    endtask

    task automatic write_coef(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx < NUM_COEF_REGS)
            hash_coef[idx] = value[COEF_W-1:0];
        coef_writes++;
        @(negedge aclk);
    endtask

    // Stop sending, wait for every outstanding estimate, then let any add in
    // flight finish for settle_cycles
    task automatic drain_results(input int settle_cycles);
        s_valid <= 1'b0;
        while (pending_estimates.size() != 0) @(posedge aclk);
        repeat (settle_cycles) @(posedge aclk);
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_estimates.size() == 0) begin
                report_error("result transaction with no estimate outstanding");
            end else begin
                want = pending_estimates.pop_front();
                if (m_data.estimate !== want.estimate)
                    report_error($sformatf("estimate got %h want %h",
                                           m_data.estimate, want.estimate));
                if (m_data.total !== want.total)
                    report_error($sformatf("total got %h want %h",
                                           m_data.total, want.total));
                checked_count++;
            end
        end
    end

    // Fresh sketch: every estimate is zero whatever the key
    task automatic test_empty_sketch();
        send_op(CMD_ESTIMATE, 32'h0000_0000, 32'h7FFF_FFFF);
        send_op(CMD_ESTIMATE, 32'hFFFF_FFFF, 32'h8000_0000);
        send_op(CMD_ESTIMATE, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(CMD_ESTIMATE, 32'h7FFF_FFFF, 32'h0000_0001);
    endtask

    // Reset coefficients; key and increment extremes, counter and total wrap
    task automatic test_field_extremes();
        send_op(CMD_ADD,      32'h0000_0000, 32'h7FFF_FFFF);
        send_op(CMD_ADD,      32'h0000_0000, 32'h7FFF_FFFF);
        send_op(CMD_ESTIMATE, 32'h0000_0000, 32'h0000_0000);
        send_op(CMD_ADD,      32'h0000_0000, 32'h0000_0002);
        send_op(CMD_ESTIMATE, 32'h0000_0000, 32'h0000_0000);
        send_op(CMD_ADD,      32'hFFFF_FFFF, 32'h8000_0000);
        send_op(CMD_ADD,      32'h8000_0000, 32'hFFFF_FFFF);
        send_op(CMD_ESTIMATE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_op(CMD_ADD,      32'h7FFF_FFFF, 32'h0000_0001);
        send_op(CMD_ESTIMATE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_op(CMD_ADD,      32'h1234_5678, 32'h0000_0000);
        send_op(CMD_ESTIMATE, 32'h8000_0000, 32'h0000_0000);
    endtask

    // Coefficient extremes, zero coefficients, masked top bit, ignored indexes
    task automatic test_coef_registers();
        drain_results(SETTLE_CYCLES);
        write_coef(REG_ROW0_MULT, 32'h7FFF_FFFF);
        write_coef(REG_ROW0_ADD,  32'h7FFF_FFFF);
        write_coef(REG_ROW1_MULT, 32'h0000_0000);
        write_coef(REG_ROW1_ADD,  32'h0000_0000);
        write_coef(REG_ROW2_MULT, 32'h0000_0001);
        write_coef(REG_ROW2_ADD,  32'hFFFF_FFFF);
        write_coef(REG_ROW3_MULT, $urandom() | 32'h8000_0000);
        write_coef(REG_ROW3_ADD,  $urandom());
        for (int i = NUM_COEF_REGS; i < 2 ** CFG_IDX_W; i++)
            write_coef(cfg_idx_t'(i), $urandom());
        cfg_valid <= 1'b0;
        send_op(CMD_ADD,      32'h7FFF_FFFF, 32'h0000_0005);
        send_op(CMD_ADD,      32'h8000_0000, 32'h0000_0007);
        send_op(CMD_ADD,      32'hFFFF_FFFF, 32'h0000_0009);
        send_op(CMD_ADD,      32'h0000_0000, 32'h0000_000B);
        send_op(CMD_ESTIMATE, 32'h7FFF_FFFF, 32'h0000_0000);
        send_op(CMD_ESTIMATE, 32'h8000_0000, 32'h0000_0000);
        send_op(CMD_ESTIMATE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_op(CMD_ESTIMATE, 32'h0000_0000, 32'h0000_0000);
    endtask

    // Random traffic over a small key set per phase so estimates collide
    // with earlier adds; a fresh coefficient setting for each phase.
    task automatic test_random_traffic();
        logic [31:0] key_pool [KEY_POOL];
        logic [31:0] key;
        logic [31:0] inc;
        logic [31:0] value;
        logic        cmd;
        int          pick;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results(SETTLE_CYCLES);
            for (int r = 0; r < NUM_COEF_REGS; r++) begin
                case (phase)
                    0: value = 32'hFFFF_FFFF;
                    1: value = 32'h0000_0001;
                    2: value = ($urandom_range(3) == 0) ? 32'h0 : $urandom();
                    default: value = $urandom();
                endcase
                write_coef(cfg_idx_t'(r), value);
            end
            cfg_valid <= 1'b0;
            foreach (key_pool[i])
                key_pool[i] = $urandom();
            key_pool[KEY_POOL-1] = phase[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            if (phase == 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else begin
                src_idle_pct = 24;
                snk_idle_pct = 24;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 4 && n == ITEMS_PER_PHASE / 2)
                    drain_results(0);
                key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL-1)]
                                                : $urandom();
                pick = $urandom_range(99);
                if (pick < 60)
                    inc = $urandom_range(200) - 100;
                else if (pick < 85)
                    inc = $urandom();
                else
                    case ($urandom_range(2))
                        0: inc = 32'h7FFF_FFFF;
                        1: inc = 32'h8000_0000;
                        default: inc = 32'hFFFF_FFFF;
                    endcase
                cmd = ($urandom_range(99) < 45) ? CMD_ESTIMATE : CMD_ADD;
                send_op(cmd, key, inc);
            end
        end
        src_idle_pct = 24;
        snk_idle_pct = 24;
    endtask

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d estimates outstanding",
                 cycle_count, pending_estimates.size());
        $display("count_min_sketch: mismatch");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        foreach (hash_coef[i])
            hash_coef[i] = 1;
        foreach (row_counters[r, c])
            row_counters[r][c] = '0;
        running_total = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_sketch();
        test_field_extremes();
        test_coef_registers();
        test_random_traffic();
        drain_results(SETTLE_CYCLES);

        $display("%0d adds and %0d estimates sent, %0d results checked",
                 add_count, est_count, checked_count);
        $display("%0d coefficient writes across %0d hash settings, %0d errors",
                 coef_writes, NUM_PHASES + 2, error_count);
        if (error_count == 0)
            $display("count_min_sketch: match");
        else
            $display("count_min_sketch: mismatch");
        $finish;
    end

endmodule
